// ===== rtl/core/prl_pkg.sv =====
// ---------------------------------------------------------------------------
// prl_pkg: shared types and constants for the positional record list
// Field widths, stream packing offsets, request codes and the structs that
// travel between the control logic and the record cells.
// ---------------------------------------------------------------------------
package prl_pkg;

    localparam int unsigned DEFAULT_CAPACITY = 64;

    localparam int unsigned ACT_W   = 3;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned PAY_W   = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned FOUND_W = 6;
    localparam int unsigned LEN_W   = 7;

    // input tdata: action, position, entry_id, entry_payload
    localparam int unsigned IN_ACT_LSB  = 0;
    localparam int unsigned IN_POS_LSB  = IN_ACT_LSB + ACT_W;
    localparam int unsigned IN_ID_LSB   = IN_POS_LSB + POS_W;
    localparam int unsigned IN_PAY_LSB  = IN_ID_LSB + ID_W;
    localparam int unsigned IN_USED_W   = IN_PAY_LSB + PAY_W;
    localparam int unsigned IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // output tdata: status, found_index, out_id, out_payload, list_length
    localparam int unsigned OUT_STAT_LSB  = 0;
    localparam int unsigned OUT_FOUND_LSB = OUT_STAT_LSB + STAT_W;
    localparam int unsigned OUT_ID_LSB    = OUT_FOUND_LSB + FOUND_W;
    localparam int unsigned OUT_PAY_LSB   = OUT_ID_LSB + ID_W;
    localparam int unsigned OUT_LEN_LSB   = OUT_PAY_LSB + PAY_W;
    localparam int unsigned OUT_USED_W    = OUT_LEN_LSB + LEN_W;
    localparam int unsigned OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_MODIFY = 3'd2,
        ACT_SEARCH = 3'd3,
        ACT_GET    = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE     = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_MODIFY
    } t_cmd_op;

    typedef enum logic {
        PRB_SEARCH,
        PRB_GET
    } t_probe_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] payload;
    } t_rec;

    // broadcast edit applied by every cell in the same cycle
    typedef struct packed {
        t_cmd_op          op;
        logic [POS_W-1:0] pos;
        t_rec             rec;
    } t_cmd;

    // lookup token handed from cell to cell, one hop per cycle
    typedef struct packed {
        logic               valid;
        t_probe_kind        kind;
        logic               hit;
        logic [ID_W-1:0]    key;
        logic [POS_W-1:0]   pos;
        logic [FOUND_W-1:0] found;
        t_rec               rec;
    } t_probe;

    typedef struct packed {
        t_status            status;
        logic [FOUND_W-1:0] found;
        t_rec               rec;
    } t_result;

endpackage

// ===== rtl/core/prl_cell.sv =====
// ---------------------------------------------------------------------------
// prl_cell: one slot of the record list
// Holds one record, shifts it to or from a neighbor on insert and remove,
// and forwards the lookup token, marking it on the first match.
// ---------------------------------------------------------------------------
module prl_cell
    import prl_pkg::*;
#(
    parameter int unsigned CAPACITY = DEFAULT_CAPACITY,
    parameter int unsigned IDX      = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_cmd                               i_cmd,
    input  t_rec                               i_left_rec,
    input  t_rec                               i_right_rec,
    input  logic [$clog2(CAPACITY + 1)-1:0]    i_count,
    input  t_probe                             i_probe,
    output t_rec                               o_rec,
    output t_probe                             o_probe
);

    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0]   MY_IDX   = CMP_W'(IDX);
    localparam logic [FOUND_W-1:0] MY_FOUND = FOUND_W'(IDX);

    t_rec   r_rec;
    t_rec   n_rec;
    t_probe r_probe;
    t_probe n_probe;

    logic [CMP_W-1:0] w_cmd_pos;
    logic [CMP_W-1:0] w_prb_pos;
    logic             w_occupied;

    assign w_cmd_pos  = CMP_W'(i_cmd.pos);
    assign w_prb_pos  = CMP_W'(i_probe.pos);
    assign w_occupied = MY_IDX < CMP_W'(i_count);

    always_comb begin
        n_rec = r_rec;
        case (i_cmd.op)
            CMD_INSERT: begin
                if (MY_IDX > w_cmd_pos) begin
                    n_rec = i_left_rec;
                end else if (MY_IDX == w_cmd_pos) begin
                    n_rec = i_cmd.rec;
                end
            end
            CMD_REMOVE: begin
                if (MY_IDX >= w_cmd_pos) begin
                    n_rec = i_right_rec;
                end
            end
            CMD_MODIFY: begin
                if (MY_IDX == w_cmd_pos) begin
                    n_rec = i_cmd.rec;
                end
            end
            default: begin
                n_rec = r_rec;
            end
        endcase
    end

    always_comb begin
        n_probe = i_probe;
        // first match wins: later cells leave a marked token alone
        if (i_probe.valid && !i_probe.hit && w_occupied) begin
            case (i_probe.kind)
                PRB_SEARCH: begin
                    if (r_rec.id == i_probe.key) begin
                        n_probe.hit   = 1'b1;
                        n_probe.found = MY_FOUND;
                    end
                end
                PRB_GET: begin
                    if (w_prb_pos == MY_IDX) begin
                        n_probe.hit = 1'b1;
                        n_probe.rec = r_rec;
                    end
                end
                default: begin
                    n_probe = i_probe;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_rec   = r_rec;
    assign o_probe = r_probe;

endmodule

// ===== rtl/core/positional_record_list.sv =====
// Result path: insert, remove, modify and rejected requests register their
//   result in the pending register, then in the output register; search and
//   get first walk the lookup token down the cell chain, one cell per cycle.
// Flow: one request at a time; the next is taken as soon as the result moves
//   to the output register, and that move waits while the output is stalled.
// Reset (synchronous, active low) empties the list; no clearing pass is needed.
// ---------------------------------------------------------------------------
// positional_record_list: ordered list of id/payload records
// A chain of cells holds the records; edits shift every cell in the same cycle and
// lookups walk a token down the chain.
// ---------------------------------------------------------------------------
module positional_record_list
    import prl_pkg::*;
#(
    parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // action, position, entry_id, entry_payload (lowest bit up)
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status, found_index, out_id, out_payload, list_length (lowest bit up)
    output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    t_result               r_pend;
    t_result               n_pend;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out;

    logic                  w_accept;
    logic                  w_start_walk;
    logic                  w_load_out;
    t_cmd                  w_cmd;
    t_probe                w_probe_in;
    t_probe                w_probe [CAPACITY+1];
    t_rec                  w_rec [CAPACITY];

    logic [ACT_W-1:0]      w_action;
    logic [POS_W-1:0]      w_position;
    t_rec                  w_new_rec;
    logic [CMP_W-1:0]      w_pos_ext;
    logic [CMP_W-1:0]      w_cnt_ext;
    logic                  w_full;

    assign w_action          = s_axis_tdata[IN_POS_LSB-1:IN_ACT_LSB];
    assign w_position        = s_axis_tdata[IN_ID_LSB-1:IN_POS_LSB];
    assign w_new_rec.id      = s_axis_tdata[IN_PAY_LSB-1:IN_ID_LSB];
    assign w_new_rec.payload = s_axis_tdata[IN_USED_W-1:IN_PAY_LSB];

    assign w_pos_ext = CMP_W'(w_position);
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_full    = r_count >= CNT_W'(CAPACITY);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load_out    = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_start_walk ? S_WALK : S_EMIT;
                end
            end
            S_WALK: begin
                if (w_probe[CAPACITY].valid) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // request decode, edit command, token injection, pending result
    always_comb begin
        w_cmd          = '0;
        w_cmd.op       = CMD_NONE;
        w_cmd.pos      = w_position;
        w_cmd.rec      = w_new_rec;
        w_probe_in     = '0;
        w_probe_in.key = w_new_rec.id;
        w_probe_in.pos = w_position;
        w_start_walk   = 1'b0;
        n_count        = r_count;
        n_pend         = r_pend;

        if (w_accept) begin
            n_pend        = '0;
            n_pend.status = ST_DONE;
            case (t_action'(w_action))
                ACT_INSERT: begin
                    if (w_pos_ext > w_cnt_ext) begin
                        n_pend.status = ST_BADPOS;
                    end else if (w_full) begin
                        n_pend.status = ST_FULL;
                    end else begin
                        w_cmd.op = CMD_INSERT;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                ACT_REMOVE: begin
                    if (w_pos_ext >= w_cnt_ext) begin
                        n_pend.status = ST_BADPOS;
                    end else begin
                        w_cmd.op = CMD_REMOVE;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                ACT_MODIFY: begin
                    if (w_pos_ext >= w_cnt_ext) begin
                        n_pend.status = ST_BADPOS;
                    end else begin
                        w_cmd.op = CMD_MODIFY;
                    end
                end
                ACT_SEARCH: begin
                    w_probe_in.valid = 1'b1;
                    w_probe_in.kind  = PRB_SEARCH;
                    w_start_walk     = 1'b1;
                end
                ACT_GET: begin
                    if (w_pos_ext >= w_cnt_ext) begin
                        n_pend.status = ST_BADPOS;
                    end else begin
                        w_probe_in.valid = 1'b1;
                        w_probe_in.kind  = PRB_GET;
                        w_start_walk     = 1'b1;
                    end
                end
                default: begin
                    n_pend.status = ST_BADPOS;
                end
            endcase
        end else if (r_state == S_WALK && w_probe[CAPACITY].valid) begin
            n_pend = '0;
            if (w_probe[CAPACITY].hit) begin
                n_pend.status = ST_DONE;
                if (w_probe[CAPACITY].kind == PRB_SEARCH) begin
                    n_pend.found = w_probe[CAPACITY].found;
                end else begin
                    n_pend.rec = w_probe[CAPACITY].rec;
                end
            end else begin
                n_pend.status = (w_probe[CAPACITY].kind == PRB_SEARCH) ? ST_NOTFOUND
                                                                       : ST_BADPOS;
            end
        end
    end

    assign w_probe[0] = w_probe_in;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_rec w_left;
        t_rec w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_rec[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_rec[g+1];
        end

        prl_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_left_rec  (w_left),
            .i_right_rec (w_right),
            .i_count     (r_count),
            .i_probe     (w_probe[g]),
            .o_rec       (w_rec[g]),
            .o_probe     (w_probe[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (w_load_out) begin
            r_out <= {
                {(OUT_DATA_W - OUT_USED_W){1'b0}},
                LEN_W'(r_count),
                r_pend.rec.payload,
                r_pend.rec.id,
                r_pend.found,
                r_pend.status
            };
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

// ===== rtl/core/prl_checker.sv =====
// ---------------------------------------------------------------------------
// prl_checker: port-level checks for the positional record list
// Watches the result stream and flags results that cannot occur.
// ---------------------------------------------------------------------------
module prl_checker
    import prl_pkg::*;
#(
    parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    logic [STAT_W-1:0]  w_status;
    logic [FOUND_W-1:0] w_found;
    logic [ID_W-1:0]    w_id;
    logic [PAY_W-1:0]   w_pay;
    logic [LEN_W-1:0]   w_len;
    logic               w_in_req;

    assign w_status = m_axis_tdata[OUT_FOUND_LSB-1:OUT_STAT_LSB];
    assign w_found  = m_axis_tdata[OUT_ID_LSB-1:OUT_FOUND_LSB];
    assign w_id     = m_axis_tdata[OUT_PAY_LSB-1:OUT_ID_LSB];
    assign w_pay    = m_axis_tdata[OUT_LEN_LSB-1:OUT_PAY_LSB];
    assign w_len    = m_axis_tdata[OUT_USED_W-1:OUT_LEN_LSB];
    assign w_in_req = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (CAPACITY > 127) || (32'(w_len) <= CAPACITY))
        else $error("list length above capacity");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == ST_FULL) |-> (w_len == LEN_W'(CAPACITY)))
        else $error("list full reported on a list that is not full");

    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_found != '0) |-> (w_status == ST_DONE))
        else $error("found index on a failed request");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((w_id != '0) || (w_pay != '0)) && !w_in_req
            |-> (w_status == ST_DONE))
        else $error("record data on a failed request");

endmodule

bind positional_record_list prl_checker #(.CAPACITY(CAPACITY)) u_prl_checker (.*);
